// ===== sv/langton_ant_grid_stepper_top_assert.svh =====
// Assertion macros shared by the checker of the grid stepper.
`ifndef LANGTON_ANT_GRID_STEPPER_TOP_ASSERT_SVH
`define LANGTON_ANT_GRID_STEPPER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LAGS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LAGS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/lags_pkg.sv =====
// Package with the shared types and codes of the grid stepper.
`default_nettype none
package lags_pkg;

	typedef logic [1:0] halt_t;
	typedef logic [1:0] head_t;
	typedef logic [1:0] reg_idx_t;

	// Halt causes.
	localparam halt_t HALT_RUN   = 2'd0;
	localparam halt_t HALT_LIMIT = 2'd1;
	localparam halt_t HALT_OFF   = 2'd2;

	// Headings and the move each one makes.
	localparam head_t HEAD_ROW_INC = 2'd0;
	localparam head_t HEAD_COL_INC = 2'd1;
	localparam head_t HEAD_ROW_DEC = 2'd2;
	localparam head_t HEAD_COL_DEC = 2'd3;

	// Item functions.
	localparam logic FUNC_STEP = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	// Register indexes.
	localparam reg_idx_t REG_GRID_WIDTH  = 2'd0;
	localparam reg_idx_t REG_GRID_HEIGHT = 2'd1;
	localparam reg_idx_t REG_STEP_LIMIT  = 2'd2;

	// Register reset values.
	localparam logic [8:0]  GRID_W_RESET = 9'd256;
	localparam logic [8:0]  GRID_H_RESET = 9'd256;
	localparam logic [31:0] LIMIT_RESET  = 32'd11000;

endpackage
`default_nettype wire

// ===== sv/lags_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module lags_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data holds while no read is requested.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== sv/langton_ant_grid_stepper_top.sv =====
// Top level of the Langton's ant grid stepper.
//
// Channel  Direction  Handshake            Payload
// in       request    in_valid / in_stall  func, read_col, read_row
// out      result     out_valid/out_stall  cell_value, ant_col, ant_row, heading,
//                                          steps_done, halt_cause
// cfg      write      cfg_we               cfg_index, cfg_data
//
// The grid RAM is read in the accept cycle of a request; in ST_EXEC, once the output
// register is free, the cell is flipped, written back and the result is registered.
// After reset a clearing pass writes MAX_ROWS*MAX_COLS cells, one a cycle, with
// in_stall high; configuration writes are taken during it.
// While the output register is full and stalled, a request waits in ST_EXEC.
`default_nettype none
module langton_ant_grid_stepper_top
	import lags_pkg::*;
#(
	parameter int MAX_COLS = 256,
	parameter int MAX_ROWS = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        func,
	input  wire logic [7:0]  read_col,
	input  wire logic [7:0]  read_row,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             cell_value,
	output logic      [8:0]  ant_col,
	output logic      [8:0]  ant_row,
	output logic      [1:0]  heading,
	output logic      [31:0] steps_done,
	output logic      [1:0]  halt_cause,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int Depth = MAX_COLS * MAX_ROWS;
	localparam int AW = $clog2(Depth);
	localparam logic [AW-1:0] LastAddr = AW'(Depth - 1);
	localparam logic [8:0] MaxColsV = 9'(MAX_COLS);
	localparam logic [8:0] MaxRowsV = 9'(MAX_ROWS);
	localparam logic [8:0] ResetColsV = (GRID_W_RESET > MaxColsV) ? MaxColsV : GRID_W_RESET;
	localparam logic [8:0] ResetRowsV = (GRID_H_RESET > MaxRowsV) ? MaxRowsV : GRID_H_RESET;

	// Sequencer states.
	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;

	// Linear cell address of a row and column.
	function automatic logic [AW-1:0] cell_addr(input logic [8:0] row, input logic [8:0] col);
		logic [17:0] lin;
		lin = 18'(row) * 18'(MAX_COLS) + 18'(col);
		return lin[AW-1:0];
	endfunction

	logic [1:0]    state_q;
	logic [AW-1:0] clr_q;
	logic [8:0]    width_q;
	logic [8:0]    height_q;
	logic [31:0]   limit_q;
	logic [8:0]    ant_x_q;
	logic [8:0]    ant_y_q;
	head_t         head_q;
	logic [31:0]   steps_q;
	halt_t         halt_q;
	logic          func_q;
	logic          rd_ok_q;
	logic          out_valid_q;
	logic          cell_q;
	logic [8:0]    col_q;
	logic [8:0]    row_q;
	head_t         head_out_q;
	logic [31:0]   steps_out_q;
	halt_t         halt_out_q;

	logic          accept;
	logic          go;
	logic          take;
	logic          step_live;
	logic [8:0]    cols_use;
	logic [8:0]    rows_use;
	logic [8:0]    cfg_cols;
	logic [8:0]    cfg_rows;
	logic          fresh;
	halt_t         cause_now;
	halt_t         cause_nx;
	halt_t         halt_after;
	logic          was_black;
	head_t         head_nx;
	logic [8:0]    x_nx;
	logic [8:0]    y_nx;
	logic [31:0]   steps_nx;
	logic          cell_res;
	logic          rd_ok;
	logic [AW-1:0] ant_addr;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic          ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic          ram_rdata;

	// Handshake.
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign go       = (state_q == ST_EXEC) && (!out_valid_q || !out_stall);

	// Grid size in use and halt checks before and after a step.
	assign cols_use  = (width_q > MaxColsV) ? MaxColsV : width_q;
	assign rows_use  = (height_q > MaxRowsV) ? MaxRowsV : height_q;
	assign cause_now = (steps_q >= limit_q) ? HALT_LIMIT :
		((ant_x_q < cols_use) && (ant_y_q < rows_use)) ? HALT_RUN : HALT_OFF;
	assign step_live = (func_q == FUNC_STEP) && (halt_q == HALT_RUN);
	assign take      = step_live && (cause_now == HALT_RUN);

	// Turn on the old color, then move along the new heading.
	assign was_black = ram_rdata;
	assign head_nx   = was_black ? 2'(head_q - 2'd1) : 2'(head_q + 2'd1);
	always_comb begin
		x_nx = ant_x_q;
		y_nx = ant_y_q;
		case (head_nx)
			HEAD_ROW_INC: y_nx = 9'(ant_y_q + 9'd1);
			HEAD_COL_INC: x_nx = 9'(ant_x_q + 9'd1);
			HEAD_ROW_DEC: y_nx = 9'(ant_y_q - 9'd1);
			HEAD_COL_DEC: x_nx = 9'(ant_x_q - 9'd1);
			default:      x_nx = ant_x_q;
		endcase
	end
	assign steps_nx = steps_q + 32'd1;
	assign cause_nx = (steps_nx >= limit_q) ? HALT_LIMIT :
		((x_nx < cols_use) && (y_nx < rows_use)) ? HALT_RUN : HALT_OFF;

	// Halt state and cell shown in the result.
	always_comb begin
		if (!step_live) begin
			halt_after = halt_q;
		end else if (cause_now != HALT_RUN) begin
			halt_after = cause_now;
		end else begin
			halt_after = cause_nx;
		end
	end
	assign cell_res = (func_q == FUNC_READ) ? (rd_ok_q & ram_rdata) : (take & ~ram_rdata);

	// Read requests outside the store return zero.
	assign rd_ok    = ({1'b0, read_col} < MaxColsV) && ({1'b0, read_row} < MaxRowsV);
	assign ant_addr = cell_addr(ant_y_q, ant_x_q);

	// RAM port selection: clearing pass, read on accept, write-back on a step.
	always_comb begin
		ram_re    = accept;
		ram_raddr = (func == FUNC_READ) ? cell_addr({1'b0, read_row}, {1'b0, read_col})
			: ant_addr;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = 1'b0;
		end else begin
			ram_we    = go && take;
			ram_waddr = ant_addr;
			ram_wdata = ~ram_rdata;
		end
	end

	lags_ram #(
		.WIDTH(1),
		.DEPTH(Depth)
	) u_grid_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Sequencer and clearing counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= AW'(clr_q + 1'b1);
					if (clr_q == LastAddr) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request fields kept for ST_EXEC.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func;
			rd_ok_q <= rd_ok;
		end
	end

	// Recentering values for a grid size write.
	assign fresh    = (steps_q == 32'd0) && (halt_q == HALT_RUN);
	assign cfg_cols = (cfg_data[8:0] > MaxColsV) ? MaxColsV : cfg_data[8:0];
	assign cfg_rows = (cfg_data[8:0] > MaxRowsV) ? MaxRowsV : cfg_data[8:0];

	// Configuration registers and ant state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= GRID_W_RESET;
			height_q <= GRID_H_RESET;
			limit_q  <= LIMIT_RESET;
			ant_x_q  <= ResetColsV >> 1;
			ant_y_q  <= ResetRowsV >> 1;
			head_q   <= HEAD_ROW_INC;
			steps_q  <= '0;
			halt_q   <= HALT_RUN;
		end else if (go) begin
			if (step_live) begin
				halt_q <= halt_after;
			end
			if (take) begin
				ant_x_q <= x_nx;
				ant_y_q <= y_nx;
				head_q  <= head_nx;
				steps_q <= steps_nx;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_WIDTH: begin
					width_q <= cfg_data[8:0];
					if (fresh) begin
						ant_x_q <= cfg_cols >> 1;
					end
				end
				REG_GRID_HEIGHT: begin
					height_q <= cfg_data[8:0];
					if (fresh) begin
						ant_y_q <= cfg_rows >> 1;
					end
				end
				REG_STEP_LIMIT: limit_q <= cfg_data;
				default: limit_q <= limit_q;
			endcase
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (go) begin
			cell_q      <= cell_res;
			col_q       <= take ? x_nx : ant_x_q;
			row_q       <= take ? y_nx : ant_y_q;
			head_out_q  <= take ? head_nx : head_q;
			steps_out_q <= take ? steps_nx : steps_q;
			halt_out_q  <= halt_after;
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_value = cell_q;
	assign ant_col    = col_q;
	assign ant_row    = row_q;
	assign heading    = head_out_q;
	assign steps_done = steps_out_q;
	assign halt_cause = halt_out_q;

endmodule
`default_nettype wire

// ===== sv/lags_checker.sv =====
// Port-level checker of the grid stepper and its bind to the top level.
`default_nettype none
`include "langton_ant_grid_stepper_top_assert.svh"
module lags_checker
	import lags_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        cell_value,
	input wire logic [8:0]  ant_col,
	input wire logic [8:0]  ant_row,
	input wire logic [1:0]  heading,
	input wire logic [31:0] steps_done,
	input wire logic [1:0]  halt_cause
);

	logic        seen_q;
	halt_t       last_halt_q;
	logic [31:0] last_steps_q;
	logic [8:0]  last_col_q;
	logic [8:0]  last_row_q;
	head_t       last_head_q;

	// Last result taken from the output channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q       <= 1'b0;
			last_halt_q  <= HALT_RUN;
			last_steps_q <= '0;
			last_col_q   <= '0;
			last_row_q   <= '0;
			last_head_q  <= HEAD_ROW_INC;
		end else if (out_valid && !out_stall) begin
			seen_q       <= 1'b1;
			last_halt_q  <= halt_cause;
			last_steps_q <= steps_done;
			last_col_q   <= ant_col;
			last_row_q   <= ant_row;
			last_head_q  <= heading;
		end
	end

	// A stalled result holds.
	`LAGS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(cell_value) && $stable(steps_done) && $stable(halt_cause),
		"stalled result changed")

	// Once halted, the cause never changes.
	`LAGS_ASSERT_NOW(a_halt_sticky, clk, arst_n, out_valid && (last_halt_q != HALT_RUN),
		halt_cause == last_halt_q, "halt cause changed after a halt")

	// The step count advances by at most one between results.
	`LAGS_ASSERT_NOW(a_steps_inc, clk, arst_n, out_valid && seen_q,
		(steps_done == last_steps_q) || (steps_done == last_steps_q + 32'd1),
		"step count jumped")

	// A halted ant does not move or turn.
	`LAGS_ASSERT_NOW(a_halt_frozen, clk, arst_n, out_valid && (last_halt_q != HALT_RUN),
		(ant_col == last_col_q) && (ant_row == last_row_q) && (heading == last_head_q),
		"halted ant moved")

endmodule

bind langton_ant_grid_stepper_top lags_checker u_lags_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.cell_value(cell_value),
	.ant_col   (ant_col),
	.ant_row   (ant_row),
	.heading   (heading),
	.steps_done(steps_done),
	.halt_cause(halt_cause)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the Langton's ant grid stepper, with its own model of the ant.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import lags_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int RESET_CYCLES = 12;
	localparam int IDLE_LIMIT   = 300000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 8;
	localparam int FINAL_CYCLES = 20;

	// Index with no register behind it; writes to it must be ignored.
	localparam reg_idx_t REG_NONE = 2'd3;

	typedef struct packed {
		logic       fn;
		logic [7:0] col;
		logic [7:0] row;
	} ant_req_t;

	typedef struct packed {
		logic        color;
		logic [8:0]  col;
		logic [8:0]  row;
		head_t       dir;
		logic [31:0] steps;
		halt_t       cause;
	} ant_res_t;

	// Ways of bringing the walk to a halt near the end of the run.
	typedef enum int {
		END_ZERO_LIMIT,
		END_NEAR_LIMIT,
		END_NARROW_GRID,
		END_WALK_OFF
	} end_plan_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        func = 1'b0;
	logic [7:0]  read_col = 8'd0;
	logic [7:0]  read_row = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        cell_value;
	logic [8:0]  ant_col;
	logic [8:0]  ant_row;
	logic [1:0]  heading;
	logic [31:0] steps_done;
	logic [1:0]  halt_cause;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = 2'd0;
	logic [31:0] cfg_data = 32'd0;

	langton_ant_grid_stepper_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.read_col   (read_col),
		.read_row   (read_row),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cell_value (cell_value),
		.ant_col    (ant_col),
		.ant_row    (ant_row),
		.heading    (heading),
		.steps_done (steps_done),
		.halt_cause (halt_cause),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// Model state: the grid, the ant and the register copies.
	bit          grid_bits [0:65535];
	logic [8:0]  walk_col;
	logic [8:0]  walk_row;
	head_t       walk_dir;
	logic [31:0] walk_steps;
	halt_t       walk_halt;
	logic [8:0]  cols_cfg;
	logic [8:0]  rows_cfg;
	logic [31:0] limit_cfg;

	// Pending requests, expected results and bookkeeping.
	ant_req_t ant_reqs_q[$];
	ant_res_t ant_results_q[$];
	ant_req_t sent_req;
	ant_res_t want_res;
	int       n_queued;
	int       n_accepted;
	int       n_results;
	int       n_steps;
	int       n_reads;
	int       n_writes;
	int       errors;
	int       send_gap;
	int       stall_left;
	int       open_left;
	int       hold_count;
	int       idle_cycles;
	bit       no_gaps;
	bit       hold_go;

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic logic [8:0] cols_used();
		return (cols_cfg > 9'd256) ? 9'd256 : cols_cfg;
	endfunction

	function automatic logic [8:0] rows_used();
		return (rows_cfg > 9'd256) ? 9'd256 : rows_cfg;
	endfunction

	// The limit is checked before the grid bounds.
	function automatic halt_t halt_reason();
		if (walk_steps >= limit_cfg)
			return HALT_LIMIT;
		if (walk_col >= cols_used() || walk_row >= rows_used())
			return HALT_OFF;
		return HALT_RUN;
	endfunction

	// Applies one request to the model and returns the result it should produce.
	function automatic ant_res_t advance_ant(ant_req_t r);
		ant_res_t res;
		logic     was_black;
		halt_t    cause;
		res.color = 1'b0;
		if (r.fn == FUNC_READ) begin
			res.color = grid_bits[{r.row, r.col}];
		end else if (walk_halt == HALT_RUN) begin
			cause = halt_reason();
			if (cause != HALT_RUN) begin
				walk_halt = cause;
			end else begin
				was_black = grid_bits[{walk_row[7:0], walk_col[7:0]}];
				grid_bits[{walk_row[7:0], walk_col[7:0]}] = !was_black;
				res.color = !was_black;
				walk_dir = was_black ? walk_dir - 2'd1 : walk_dir + 2'd1;
				case (walk_dir)
					HEAD_ROW_INC: walk_row = walk_row + 9'd1;
					HEAD_COL_INC: walk_col = walk_col + 9'd1;
					HEAD_ROW_DEC: walk_row = walk_row - 9'd1;
					default:      walk_col = walk_col - 9'd1;
				endcase
				walk_steps = walk_steps + 32'd1;
				walk_halt = halt_reason();
			end
		end
		res.col   = walk_col;
		res.row   = walk_row;
		res.dir   = walk_dir;
		res.steps = walk_steps;
		res.cause = walk_halt;
		return res;
	endfunction

	// A size written before the first step recenters the ant on that axis.
	function automatic void apply_reg(reg_idx_t idx, logic [31:0] val);
		bit fresh;
		fresh = (walk_steps == 32'd0) && (walk_halt == HALT_RUN);
		case (idx)
			REG_GRID_WIDTH: begin
				cols_cfg = val[8:0];
				if (fresh)
					walk_col = cols_used() >> 1;
			end
			REG_GRID_HEIGHT: begin
				rows_cfg = val[8:0];
				if (fresh)
					walk_row = rows_used() >> 1;
			end
			REG_STEP_LIMIT: begin
				limit_cfg = val;
			end
			default: begin
			end
		endcase
	endfunction

	// Mostly no gap, sometimes a short one, rarely a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Mostly steps; reads aim at the trail, at the corners or anywhere.
	function automatic ant_req_t random_req();
		ant_req_t r;
		int       pick;
		pick  = $urandom_range(0, 99);
		r.fn  = (pick < 70) ? FUNC_STEP : FUNC_READ;
		r.col = $urandom_range(0, 255);
		r.row = $urandom_range(0, 255);
		if (pick >= 70 && pick < 88) begin
			r.col = $urandom_range(100, 155);
			r.row = $urandom_range(100, 155);
		end else if (pick >= 94) begin
			r.col = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			r.row = $urandom_range(0, 1) ? 8'd255 : 8'd0;
		end
		return r;
	endfunction

	task automatic queue_req(logic fn, logic [7:0] col, logic [7:0] row);
		ant_req_t r;
		r.fn  = fn;
		r.col = col;
		r.row = row;
		ant_reqs_q.push_back(r);
		n_queued++;
	endtask

	task automatic queue_random(int count);
		ant_req_t r;
		repeat (count) begin
			r = random_req();
			queue_req(r.fn, r.col, r.row);
		end
	endtask

	// Register writes are issued back to back; end_writes drops the enable.
	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		apply_reg(idx, val);
		n_writes++;
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Returns once every queued request has been answered and the block has settled.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (n_accepted != n_queued || ant_results_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// Request driver: predicts on acceptance, then offers the next request after a gap.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				ant_results_q.push_back(advance_ant(sent_req));
				n_accepted++;
				if (sent_req.fn == FUNC_STEP)
					n_steps++;
				else
					n_reads++;
				send_gap = no_gaps ? 0 : pick_gap();
			end
			if (!(in_valid && in_stall)) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (ant_reqs_q.size() != 0) begin
					sent_req = ant_reqs_q.pop_front();
					in_valid <= 1'b1;
					func     <= sent_req.fn;
					read_col <= sent_req.col;
					read_row <= sent_req.row;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compares with the oldest expectation and drives the stall.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				n_results++;
				if (ant_results_q.size() == 0) begin
					$error("result arrived with no request outstanding");
					errors++;
				end else begin
					want_res = ant_results_q.pop_front();
					check_field("cell_value", want_res.color, cell_value);
					check_field("ant_col", want_res.col, ant_col);
					check_field("ant_row", want_res.row, ant_row);
					check_field("heading", want_res.dir, heading);
					check_field("steps_done", want_res.steps, steps_done);
					check_field("halt_cause", want_res.cause, halt_cause);
				end
			end
			if (hold_go && hold_count < HOLD_CYCLES) begin
				out_stall <= 1'b1;
				hold_count++;
			end else if (no_gaps) begin
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (open_left > 0) begin
				out_stall <= 1'b0;
				open_left--;
			end else begin
				stall_left = pick_gap();
				open_left  = $urandom_range(1, 6);
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog on cycles with no request and no result moving; covers the clearing pass.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		end_plan_t plan;
		cols_cfg   = GRID_W_RESET;
		rows_cfg   = GRID_H_RESET;
		limit_cfg  = LIMIT_RESET;
		walk_col   = cols_used() >> 1;
		walk_row   = rows_used() >> 1;
		walk_dir   = HEAD_ROW_INC;
		walk_steps = 32'd0;
		walk_halt  = HALT_RUN;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Sizes before the first step recenter the ant; upper data bits are dropped.
		write_reg(REG_GRID_HEIGHT, 32'd0);
		write_reg(REG_GRID_WIDTH, 32'd1);
		write_reg(REG_GRID_WIDTH, 32'hFFFF_FF2C);
		write_reg(REG_GRID_HEIGHT, 32'd511);
		write_reg(REG_GRID_WIDTH, 32'h5A5A_5AFF);
		write_reg(REG_STEP_LIMIT, 32'hFFFF_FFFF);
		write_reg(REG_NONE, $urandom);
		end_writes();

		// Directed: blank reads, first steps, then reads over the fresh trail.
		queue_req(FUNC_READ, 8'd0, 8'd0);
		queue_req(FUNC_READ, 8'd255, 8'd255);
		queue_req(FUNC_READ, 8'd127, 8'd128);
		repeat (6) queue_req(FUNC_STEP, 8'd255, 8'd255);
		queue_req(FUNC_READ, 8'd127, 8'd128);
		queue_req(FUNC_READ, 8'd0, 8'd255);
		queue_req(FUNC_READ, 8'd255, 8'd0);
		repeat (8) queue_req(FUNC_STEP, $urandom, $urandom);
		queue_req(FUNC_READ, 8'd128, 8'd128);
		queue_req(FUNC_READ, 8'd127, 8'd127);
		wait_drained();

		queue_random(300);
		wait_drained();

		// Oversized width acts as the full grid and no longer moves the ant.
		write_reg(REG_GRID_WIDTH, 32'd511);
		write_reg(REG_GRID_HEIGHT, 32'd256);
		write_reg(REG_STEP_LIMIT, walk_steps + 32'd5000 + $urandom_range(0, 1000));
		end_writes();

		// A stretch without any idling.
		no_gaps = 1'b1;
		queue_random(250);
		wait_drained();

		// Receiver holds off while requests keep coming, so the input backs up.
		hold_go = 1'b1;
		queue_random(150);
		wait_drained();
		no_gaps = 1'b0;

		write_reg(REG_GRID_WIDTH, 32'd256);
		write_reg(REG_GRID_HEIGHT, 32'hFFFF_FF2C);
		write_reg(REG_STEP_LIMIT, 32'hFFFF_FFFF);
		end_writes();
		queue_random(250);
		wait_drained();

		// Bring the walk to a halt in one of several ways.
		plan = end_plan_t'($urandom_range(0, 3));
		case (plan)
			END_ZERO_LIMIT: begin
				write_reg(REG_STEP_LIMIT, 32'd0);
			end
			END_NEAR_LIMIT: begin
				write_reg(REG_STEP_LIMIT, walk_steps + $urandom_range(1, 40));
			end
			END_NARROW_GRID: begin
				write_reg(REG_GRID_WIDTH, 32'd1);
			end
			default: begin
				write_reg(REG_GRID_WIDTH, {23'd0, walk_col} + 32'd1);
				write_reg(REG_GRID_HEIGHT, {23'd0, walk_row} + 32'd1);
			end
		endcase
		end_writes();
		queue_random(120);
		wait_drained();

		// Once halted, register writes must not restart the ant.
		write_reg(REG_STEP_LIMIT, 32'd0);
		write_reg(REG_GRID_WIDTH, 32'd1);
		write_reg(REG_GRID_HEIGHT, 32'd1);
		end_writes();
		queue_random(40);
		wait_drained();

		repeat (FINAL_CYCLES) @(posedge clk);
		if (ant_results_q.size() != 0) begin
			$error("%0d expected results never arrived", ant_results_q.size());
			errors++;
		end
		$display("Covered %0d requests (%0d steps, %0d reads), %0d results, %0d register writes.",
			n_accepted, n_steps, n_reads, n_results, n_writes);
		$display("Ant stopped after %0d steps at column %0d, row %0d, halt cause %0d.",
			walk_steps, walk_col, walk_row, walk_halt);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/lags_pkg.sv
sv/lags_ram.sv
sv/langton_ant_grid_stepper_top.sv
sv/lags_checker.sv
tb/tb_top.sv
